/* rtl/core/dq_pkg.sv */
package dq_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef logic [CMD_W-1:0]    cmd_code_t;
  typedef logic [STATUS_W-1:0] status_code_t;

  localparam cmd_code_t CMD_PUSH_BACK  = 3'd0;
  localparam cmd_code_t CMD_PUSH_FRONT = 3'd1;
  localparam cmd_code_t CMD_POP_BACK   = 3'd2;
  localparam cmd_code_t CMD_POP_FRONT  = 3'd3;
  localparam cmd_code_t CMD_READ       = 3'd4;
  localparam cmd_code_t CMD_WRITE      = 3'd5;

  localparam status_code_t STAT_OK    = 2'd0;
  localparam status_code_t STAT_EMPTY = 2'd1;
  localparam status_code_t STAT_RANGE = 2'd2;
  localparam status_code_t STAT_FULL  = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the input transfer
    logic exec;   // update pointers, access storage
  } dp_cmd_t;

endpackage

/* rtl/core/dq_if.sv */
interface dq_in_if;
  logic                           valid;
  logic                           ready;
  logic [dq_pkg::CMD_W-1:0]       command;
  logic [dq_pkg::INDEX_W-1:0]     index;
  logic signed [dq_pkg::VALUE_W-1:0] value;

  modport source (output valid, command, index, value, input ready);
  modport sink   (input valid, command, index, value, output ready);
endinterface

interface dq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dq_pkg::VALUE_W-1:0] read_value;
  logic [dq_pkg::STATUS_W-1:0]       status;
  logic [dq_pkg::COUNT_W-1:0]        count;

  modport source (output valid, read_value, status, count, input ready);
  modport sink   (input valid, read_value, status, count, output ready);
endinterface

/* rtl/core/dq_ctrl.sv */
module dq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output dq_pkg::dp_cmd_t dp_cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_DONE;
      S_DONE: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_DONE);
  assign dp_cmd.load = in_ready && in_valid;
  assign dp_cmd.exec = (state_r == S_EXEC);

endmodule

/* rtl/core/dq_dp.sv */
module dq_dp #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dq_pkg::dp_cmd_t                       dp_cmd,
  input  logic [dq_pkg::CMD_W-1:0]              in_command,
  input  logic [dq_pkg::INDEX_W-1:0]            in_index,
  input  logic signed [dq_pkg::VALUE_W-1:0]     in_value,
  output logic signed [dq_pkg::VALUE_W-1:0]     out_read_value,
  output logic [dq_pkg::STATUS_W-1:0]           out_status,
  output logic [dq_pkg::COUNT_W-1:0]            out_count
);

  localparam int unsigned PW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > dq_pkg::INDEX_W) ? CW : dq_pkg::INDEX_W;
  localparam logic [PW:0]   CAP_S   = (PW + 1)'(CAPACITY);
  localparam logic [PW-1:0] LAST    = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [dq_pkg::CMD_W-1:0]   cmd_r;
  logic [dq_pkg::INDEX_W-1:0] idx_r;
  logic [DATA_WIDTH-1:0]      val_r;

  logic [PW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  dq_pkg::status_code_t stat_r, stat_nxt;
  logic                 rd_ok_r, rd_ok_nxt;
  logic [DATA_WIDTH-1:0] rdata_r;

  logic          we;
  logic [PW-1:0] addr;
  logic [PW:0]   off;
  logic [PW:0]   slot_sum;
  logic [PW-1:0] slot;
  logic [PW:0]   next_sum;
  logic [PW-1:0] head_plus1;
  logic          in_range;
  logic          is_full;
  logic          is_empty;

  // head + offset, wrapped once
  always_comb begin
    slot_sum = (PW + 1)'(head_r) + off;
    if (slot_sum >= CAP_S) slot_sum = slot_sum - CAP_S;
    slot = slot_sum[PW-1:0];
    next_sum = (PW + 1)'(head_r) + (PW + 1)'(1);
    if (next_sum >= CAP_S) next_sum = next_sum - CAP_S;
    head_plus1 = next_sum[PW-1:0];
  end

  assign in_range = CMPW'(idx_r) < CMPW'(cnt_r);
  assign is_full  = (cnt_r == CAP_CNT);
  assign is_empty = (cnt_r == '0);

  always_comb begin
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    stat_nxt  = dq_pkg::STAT_OK;
    rd_ok_nxt = 1'b0;
    we        = 1'b0;
    off       = (PW + 1)'(idx_r);
    addr      = slot;
    case (cmd_r)
      dq_pkg::CMD_PUSH_BACK: begin
        off = (PW + 1)'(cnt_r);
        if (is_full) begin
          stat_nxt = dq_pkg::STAT_FULL;
        end else begin
          we      = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      dq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) begin
          stat_nxt = dq_pkg::STAT_FULL;
        end else begin
          head_nxt = (head_r == '0) ? LAST : head_r - PW'(1);
          addr     = head_nxt;
          we       = 1'b1;
          cnt_nxt  = cnt_r + CW'(1);
        end
      end
      dq_pkg::CMD_POP_BACK: begin
        if (is_empty) stat_nxt = dq_pkg::STAT_EMPTY;
        else          cnt_nxt  = cnt_r - CW'(1);
      end
      dq_pkg::CMD_POP_FRONT: begin
        if (is_empty) begin
          stat_nxt = dq_pkg::STAT_EMPTY;
        end else begin
          head_nxt = head_plus1;
          cnt_nxt  = cnt_r - CW'(1);
        end
      end
      dq_pkg::CMD_READ: begin
        if (!in_range) stat_nxt  = dq_pkg::STAT_RANGE;
        else           rd_ok_nxt = 1'b1;
      end
      dq_pkg::CMD_WRITE: begin
        if (!in_range) stat_nxt = dq_pkg::STAT_RANGE;
        else           we       = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r <= in_command;
      idx_r <= in_index;
      val_r <= DATA_WIDTH'(in_value);
    end
  end

  // storage: one write or one registered read per command
  always_ff @(posedge clk) begin
    if (dp_cmd.exec && we) mem[addr] <= val_r;
    if (dp_cmd.exec) rdata_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else if (dp_cmd.exec) begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      stat_r  <= stat_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

  logic signed [DATA_WIDTH-1:0] rdata_s;
  assign rdata_s = rdata_r;

  assign out_read_value = rd_ok_r ? dq_pkg::VALUE_W'(rdata_s) : '0;
  assign out_status     = stat_r;
  assign out_count      = dq_pkg::COUNT_W'(cnt_r);

endmodule

/* rtl/core/double_ended_queue_top.sv */
// Double-ended queue of CAPACITY elements in a ring buffer.
// in_ch (sink): one command per transfer: push back, push front, pop back,
//   pop front, read at index, write at index; index counts from the front.
// out_ch (source): one result per command: read data (zero unless a read
//   succeeds), status (ok, empty, out of range, full) and the count after
//   the command.
// The command is registered on transfer; in the execute state the
//   pointers update and the single storage access registers the read
//   data, which the done state then shows. The controller handles one
//   command at a time and takes the next only after the result transfers.
// in_ch.ready is high only while no command is in flight.
// When the receiver stalls, the result holds on out_ch and no new command
//   is taken until it transfers.
// Reset (rst_n, synchronous, active low) empties the queue and returns the
//   controller to idle; stored elements are not cleared and are unreadable
//   until pushed or written again.
module double_ended_queue_top #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  dq_in_if.sink     in_ch,
  dq_out_if.source  out_ch
);

  dq_pkg::dp_cmd_t dp_cmd;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dp_cmd    (dp_cmd)
  );

  dq_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .dp_cmd         (dp_cmd),
    .in_command     (in_ch.command),
    .in_index       (in_ch.index),
    .in_value       (in_ch.value),
    .out_read_value (out_ch.read_value),
    .out_status     (out_ch.status),
    .out_count      (out_ch.count)
  );

endmodule

/* verif/dq_checker.sv */
module dq_checker
  import dq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [CMD_W-1:0]          in_command,
  input  logic [INDEX_W-1:0]        in_index,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [VALUE_W-1:0] out_read_value,
  input  logic [STATUS_W-1:0]       out_status,
  input  logic [COUNT_W-1:0]        out_count,
  output int                        fail_count,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [VALUE_W-1:0] read_value;
    status_code_t              status;
    logic [COUNT_W-1:0]        count;
  } deque_result_t;

  // predicted deque contents
  logic signed [VALUE_W-1:0] ring [CAPACITY];
  int unsigned               head;
  int unsigned               fill;
  deque_result_t             expected_q [$];
  int                        errors = 0;

  function automatic deque_result_t deque_apply(cmd_code_t cmd,
                                                logic [INDEX_W-1:0] idx,
                                                logic signed [VALUE_W-1:0] val);
    deque_result_t r;
    r.read_value = '0;
    r.status     = STAT_OK;
    case (cmd)
      CMD_PUSH_BACK: begin
        if (fill >= CAPACITY) r.status = STAT_FULL;
        else begin
          ring[(head + fill) % CAPACITY] = val;
          fill++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (fill >= CAPACITY) r.status = STAT_FULL;
        else begin
          head = (head == 0) ? CAPACITY - 1 : head - 1;
          ring[head] = val;
          fill++;
        end
      end
      CMD_POP_BACK: begin
        if (fill == 0) r.status = STAT_EMPTY;
        else fill--;
      end
      CMD_POP_FRONT: begin
        if (fill == 0) r.status = STAT_EMPTY;
        else begin
          head = (head + 1) % CAPACITY;
          fill--;
        end
      end
      CMD_READ: begin
        if (idx >= fill) r.status = STAT_RANGE;
        else r.read_value = ring[(head + idx) % CAPACITY];
      end
      CMD_WRITE: begin
        if (idx >= fill) r.status = STAT_RANGE;
        else ring[(head + idx) % CAPACITY] = val;
      end
      default: ;  // spare codes leave the state alone
    endcase
    r.count = COUNT_W'(fill);
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      head = 0;
      fill = 0;
      expected_q.delete();
    end else begin
      // a result never leaves on the edge its command arrives, so order is safe
      if (in_valid && in_ready)
        expected_q.insert(expected_q.size(), deque_apply(in_command, in_index, in_value));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no command pending: read_value %0d status %0d count %0d",
                 out_read_value, out_status, out_count);
          errors++;
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (out_read_value !== want.read_value) begin
            $error("read_value mismatch: expected %0d, actual %0d",
                   want.read_value, out_read_value);
            errors++;
          end
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
            errors++;
          end
          if (out_count !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, out_count);
            errors++;
          end
        end
      end
    end
    pending    <= expected_q.size();
    fail_count <= errors;
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  import dq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 16;
  localparam int          RANDOM_ITEMS = 1850;
  localparam cmd_code_t   CMD_SPARE_LO = 3'd6;
  localparam cmd_code_t   CMD_SPARE_HI = 3'd7;

  localparam int BIAS_FILL  = 0;
  localparam int BIAS_DRAIN = 1;
  localparam int BIAS_MIXED = 2;

  localparam int READY_ALWAYS = 0;
  localparam int READY_HALF   = 1;
  localparam int READY_MOSTLY = 2;

  logic clk = 1'b0;
  logic rst_n;

  dq_in_if  in_ch ();
  dq_out_if out_ch ();

  int fail_count;
  int pending;
  int queue_len  = 0;  // element count as seen from the driver
  int burst_left = 0;
  int ready_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;

  always #6 clk = ~clk;

  double_ended_queue_top #(
    .CAPACITY   (DEPTH),
    .DATA_WIDTH (VALUE_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dq_checker #(
    .CAPACITY (DEPTH)
  ) u_deque_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_command     (in_ch.command),
    .in_index       (in_ch.index),
    .in_value       (in_ch.value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_read_value (out_ch.read_value),
    .out_status     (out_ch.status),
    .out_count      (out_ch.count),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // receiver back-pressure: the ready mode is redrawn at random intervals
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(40, 300);
    end
    mode_left--;
    case (ready_mode)
      READY_ALWAYS: out_ch.ready <= 1'b1;
      READY_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
      READY_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left == 0 && $urandom_range(0, 9) == 0) hold_left = $urandom_range(1, 16);
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    endcase
  end

  // one command transfer; the sender runs in bursts, most often with an idle gap between
  task automatic issue(cmd_code_t cmd, logic [INDEX_W-1:0] idx,
                       logic signed [VALUE_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.index   <= idx;
    in_ch.value   <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (cmd)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: if (queue_len < DEPTH) queue_len++;
      CMD_POP_BACK, CMD_POP_FRONT:   if (queue_len > 0) queue_len--;
      default: ;
    endcase
  endtask

  function automatic cmd_code_t pick_cmd(int bias);
    int roll;
    int push_cut;
    int pop_cut;
    roll = $urandom_range(0, 99);
    case (bias)
      BIAS_FILL:  begin push_cut = 55; pop_cut = 70; end
      BIAS_DRAIN: begin push_cut = 15; pop_cut = 70; end
      default:    begin push_cut = 35; pop_cut = 70; end
    endcase
    if (roll < push_cut) return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    if (roll < pop_cut)  return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
    if (roll < 99)       return $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
    return $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    // mostly in range of what is held, sometimes anywhere
    if (queue_len > 0 && $urandom_range(0, 3) != 0)
      return INDEX_W'($urandom_range(0, queue_len - 1));
    return INDEX_W'($urandom_range(0, 15));
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int bias;
    int phase_len;
    int sent;
    cmd_code_t cmd;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_PUSH_BACK;
    in_ch.index    <= '0;
    in_ch.value    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue: pops underflow, index access out of range
    issue(CMD_POP_BACK, 4'd0, '0);
    issue(CMD_POP_FRONT, 4'd0, '0);
    issue(CMD_READ, 4'd0, '0);
    issue(CMD_WRITE, 4'd15, 32'h5A5A_5A5A);
    issue(CMD_SPARE_LO, 4'd15, '1);
    issue(CMD_SPARE_HI, 4'd7, 32'h8000_0000);
    // push front from head zero wraps the ring
    issue(CMD_PUSH_FRONT, 4'd0, 32'h8000_0000);
    issue(CMD_PUSH_BACK, 4'd0, 32'h7FFF_FFFF);
    for (int k = 0; k < 14; k++)
      issue(k[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, INDEX_W'(k), $urandom);
    // full queue
    issue(CMD_PUSH_BACK, 4'd0, '1);
    issue(CMD_PUSH_FRONT, 4'd0, '1);
    issue(CMD_READ, 4'd15, '0);
    issue(CMD_WRITE, 4'd15, '1);
    issue(CMD_READ, 4'd15, '0);
    issue(CMD_READ, 4'd0, '0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      bias      = $urandom_range(BIAS_FILL, BIAS_MIXED);
      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        cmd = pick_cmd(bias);
        issue(cmd, pick_index(), pick_value());
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/dq_pkg.sv
rtl/core/dq_if.sv
rtl/core/dq_ctrl.sv
rtl/core/dq_dp.sv
rtl/core/double_ended_queue_top.sv
verif/dq_checker.sv
verif/tb_top.sv
